FILE: rtl/random_sample_key_set_assert.svh
// Assertion macros shared by the RTL of the random-sample key set.
`ifndef RANDOM_SAMPLE_KEY_SET_ASSERT_SVH
`define RANDOM_SAMPLE_KEY_SET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSKS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rsks_pkg.sv
`default_nettype none

package rsks_pkg;

   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_KEY_WIDTH = 32;
   localparam int RV_WIDTH      = 16;

   typedef logic [1:0]          cmd_type;
   typedef logic [31:0]         key_type;
   typedef logic [RV_WIDTH-1:0] rv_type;
   typedef logic [2:0]          status_type;
   typedef logic [6:0]          count_out_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_GET    = 2'd2;

   localparam status_type STATUS_DONE   = 3'd0;
   localparam status_type STATUS_DUP    = 3'd1;
   localparam status_type STATUS_ABSENT = 3'd2;
   localparam status_type STATUS_FULL   = 3'd3;
   localparam status_type STATUS_EMPTY  = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/rsks_req_if.sv
`default_nettype none

interface rsks_req_if;
   import rsks_pkg::*;

   logic    valid;
   logic    ready;
   cmd_type cmd;
   key_type key;
   rv_type  random_value;

   modport source (output valid, cmd, key, random_value, input ready);
   modport sink   (input valid, cmd, key, random_value, output ready);

endinterface

`default_nettype wire

FILE: rtl/rsks_rsp_if.sv
`default_nettype none

interface rsks_rsp_if;
   import rsks_pkg::*;

   logic          valid;
   logic          ready;
   key_type       key_out;
   status_type    status;
   count_out_type count_out;

   modport source (output valid, key_out, status, count_out, input ready);
   modport sink   (input valid, key_out, status, count_out, output ready);

endinterface

`default_nettype wire

FILE: rtl/random_sample_key_set.sv
// Channel  Port    Direction  Payload
// request  req_ch  in         cmd, key, random_value
// response rsp_ch  out        key_out, status, count_out
//
// Insert and delete scan one slot per cycle and stop early on a hit; a delete that hits
// then refills the freed slot with the last key. A get on an empty set returns STATUS_EMPTY;
// otherwise get random takes random_value mod count in the remainder unit and reads that slot.
// One item at a time: req_ch.ready is high only while idle, from the cycle the result shows on rsp_ch.
// A finished item waits in the response register; a stalled rsp_ch holds it there.
// Synchronous reset empties the set at once; slot contents are left as they are.
`default_nettype none
`include "random_sample_key_set_assert.svh"

module random_sample_key_set #(
   parameter int CAPACITY  = rsks_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = rsks_pkg::DEF_KEY_WIDTH
) (
   input wire logic   clock,
   input wire logic   reset,
   rsks_req_if.sink   req_ch,
   rsks_rsp_if.source rsp_ch
);
   import rsks_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_ACT    = 3'd2;
   localparam logic [2:0] ST_DRD    = 3'd3;
   localparam logic [2:0] ST_DWR    = 3'd4;
   localparam logic [2:0] ST_MOD    = 3'd5;
   localparam logic [2:0] ST_GRD    = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   cmd_type              cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                 hit_ff, hit_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   key_type              res_key_ff, res_key_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   key_type              rsp_key_ff, rsp_key_in;
   status_type           rsp_status_ff, rsp_status_in;
   count_out_type        rsp_count_ff, rsp_count_in;

   logic [KEY_WIDTH-1:0] slots_mem [CAPACITY];
   logic [KEY_WIDTH-1:0] mem_rd_data_ff;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [KEY_WIDTH-1:0] mem_wr_data;

   logic                 req_fire;
   logic                 match_now;
   logic                 issue_go;
   logic [CNT_W-1:0]     last_idx;
   logic                 mod_start;
   logic                 mod_done;
   logic [CNT_W-1:0]     mod_rem;
   logic                 in_update;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign last_idx  = count_ff - CNT_W'(1);
   assign match_now = pend_ff && !hit_ff && (mem_rd_data_ff == key_ff);
   assign issue_go  = !hit_ff && !match_now && (issue_ff < count_ff);
   assign mod_start = req_fire && (req_ch.cmd == CMD_GET) && (count_ff != '0);
   assign in_update = (state_ff == ST_ACT) || (state_ff == ST_DWR);

   rsks_mod #(
      .CAPACITY (CAPACITY)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_ch.random_value),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      hit_in        = hit_ff;
      pos_in        = pos_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_re        = 1'b0;
      mem_rd_addr   = issue_ff[ADDR_W-1:0];
      mem_we        = 1'b0;
      mem_wr_addr   = count_ff[ADDR_W-1:0];
      mem_wr_data   = key_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_ch.cmd;
               key_in        = KEY_WIDTH'(req_ch.key);
               issue_in      = '0;
               hit_in        = 1'b0;
               res_key_in    = '0;
               res_status_in = STATUS_DONE;
               case (req_ch.cmd) inside
                  CMD_INSERT, CMD_DELETE: begin
                     state_in = ST_SCAN;
                  end
                  CMD_GET: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                        state_in      = ST_FINISH;
                     end else begin
                        state_in = ST_MOD;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Reads are issued back to back; each compare sees the data of the
            // read issued in the previous cycle.
            if (match_now) begin
               hit_in = 1'b1;
               pos_in = pend_idx_ff;
            end
            if (issue_go) begin
               mem_re      = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[ADDR_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
            end
            if (!pend_ff && !issue_go) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            if (cmd_ff == CMD_INSERT) begin
               if (hit_ff) begin
                  res_status_in = STATUS_DUP;
               end else if (count_ff >= CNT_W'(CAPACITY)) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_FINISH;
            end else if (hit_ff) begin
               state_in = ST_DRD;
            end else begin
               res_status_in = STATUS_ABSENT;
               state_in      = ST_FINISH;
            end
         end
         ST_DRD: begin
            mem_re      = 1'b1;
            mem_rd_addr = last_idx[ADDR_W-1:0];
            state_in    = ST_DWR;
         end
         ST_DWR: begin
            // The last key fills the freed slot; harmless when they coincide.
            mem_we      = 1'b1;
            mem_wr_addr = pos_ff;
            mem_wr_data = mem_rd_data_ff;
            count_in    = last_idx;
            state_in    = ST_FINISH;
         end
         ST_MOD: begin
            if (mod_done) begin
               mem_re      = 1'b1;
               mem_rd_addr = mod_rem[ADDR_W-1:0];
               state_in    = ST_GRD;
            end
         end
         ST_GRD: begin
            res_key_in = key_type'(mem_rd_data_ff);
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = res_key_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_out_type'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      issue_ff      <= issue_in;
      pend_idx_ff   <= pend_idx_in;
      pos_ff        <= pos_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_re) begin
         mem_rd_data_ff <= slots_mem[mem_rd_addr];
      end
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.key_out   = rsp_key_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.count_out = rsp_count_ff;

   `RSKS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `RSKS_ASSERT_SAME(a_write_state, clock, reset, mem_we, in_update, "slot write outside update")
   `RSKS_ASSERT_SAME(a_hit_nonempty, clock, reset, hit_ff && state_ff == ST_ACT, count_ff != '0, "hit on empty set")
   `RSKS_ASSERT_NEXT(a_count_hold, clock, reset, !in_update, $stable(count_ff), "count changed outside update")

endmodule

`default_nettype wire

FILE: rtl/rsks_mod.sv
`default_nettype none

module rsks_mod #(
   parameter int  CAPACITY = rsks_pkg::DEF_CAPACITY,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire rsks_pkg::rv_type dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic [CNT_W-1:0]      remainder
);
   import rsks_pkg::*;

   localparam int BIT_CNT_W = $clog2(RV_WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BIT_CNT_W-1:0] bits_ff, bits_in;
   rv_type               shift_ff, shift_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W:0]       trial;
   logic [CNT_W:0]       diff;

   // Restoring remainder: one dividend bit per cycle, most significant first.
   assign trial = {rem_ff, shift_ff[RV_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         bits_in  = BIT_CNT_W'(RV_WIDTH);
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[RV_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[CNT_W-1:0];
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         bits_in = bits_ff - BIT_CNT_W'(1);
         if (bits_ff == BIT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bits_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire
